// File: design/u8u16_pkg.sv
// Types and constants shared by the UTF-8 to UTF-16 transcoder.
`default_nettype none
package u8u16_pkg;

  localparam int unsigned BYTE_W = 8;
  localparam int unsigned UNIT_W = 16;
  localparam int unsigned CP_W   = 21;
  localparam int unsigned PART_W = 15;

  localparam logic [CP_W-1:0] SUPP_BASE = 21'h10000;
  localparam logic [5:0]      SURR_HI   = 6'b110110;
  localparam logic [5:0]      SURR_LO   = 6'b110111;

  localparam logic [1:0] REM_NONE  = 2'd0;
  localparam logic [1:0] REM_ONE   = 2'd1;
  localparam logic [1:0] REM_TWO   = 2'd2;
  localparam logic [1:0] REM_THREE = 2'd3;

  typedef struct packed {
    logic [UNIT_W-1:0] code_unit;
    logic              end_of_string;
    logic              last_of_run;
  } unit_t;

  typedef struct packed {
    unit_t      u0;
    unit_t      u1;
    logic [1:0] n;
  } step_res_t;

  typedef struct packed {
    logic [1:0] count;
  } obuf_status_t;

endpackage
`default_nettype wire

// File: design/u8u16_ifs.sv
// Valid/ready channel interfaces for input bytes and output code units.
`default_nettype none
interface u8u16_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  modport source (output valid, output in_byte, input ready);
  modport sink (input valid, input in_byte, output ready);
endinterface

interface u8u16_out_if;
  logic        valid;
  logic        ready;
  logic [15:0] code_unit;
  logic        end_of_string;
  logic        last_of_run;
  modport source (output valid, output code_unit, output end_of_string,
                  output last_of_run, input ready);
  modport sink (input valid, input code_unit, input end_of_string,
                input last_of_run, output ready);
endinterface
`default_nettype wire

// File: design/utf8_to_utf16_transcoder.sv
// UTF-8 to UTF-16 transcoder top level.
//
// Input channel in_ch carries one UTF-8 byte per beat; output channel out_ch
// carries one UTF-16 code unit per beat with end_of_string and last_of_run.
// A byte is held in an input register, decoded by one level of bit logic,
// and its code units (zero, one or two) land in a two-entry result register.
// The first unit of a byte appears on out_ch after the byte passes the input
// register and the result register; a surrogate pair's second unit follows
// once the first is taken. Throughput: one byte per cycle while each byte
// yields at most one unit and out_ch is ready; a byte giving a surrogate pair
// or an interrupted sequence plus ASCII holds the next byte until a unit leaves.
// Reset (synchronous, rst_n low) empties both registers and clears any
// pending sequence. When out_ch stalls, the result register holds its units
// and in_ch stops taking bytes once the input register is occupied.
// A zero byte drops any pending sequence and emits a zero terminator unit.
`default_nettype none
module utf8_to_utf16_transcoder (
  input  wire logic     clk,
  input  wire logic     rst_n,
  u8u16_in_if.sink      in_ch,
  u8u16_out_if.source   out_ch
);

  logic                             s1_valid_r;
  logic [u8u16_pkg::BYTE_W-1:0]     s1_byte_r;
  logic [u8u16_pkg::PART_W-1:0]     part_r;
  logic [u8u16_pkg::PART_W-1:0]     part_nxt;
  logic [1:0]                       rem_r;
  logic [1:0]                       rem_nxt;
  u8u16_pkg::step_res_t             res;
  u8u16_pkg::obuf_status_t          ob_status;
  logic                             can_take;
  logic                             s1_adv;
  logic                             in_acc;

  always_comb begin
    s1_adv      = s1_valid_r && can_take;
    in_ch.ready = !s1_valid_r || can_take;
    in_acc      = in_ch.valid && in_ch.ready;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_byte_r <= in_ch.in_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      part_r <= '0;
      rem_r  <= u8u16_pkg::REM_NONE;
    end else if (s1_adv) begin
      part_r <= part_nxt;
      rem_r  <= rem_nxt;
    end
  end

  u8u16_step u_step (
    .byte_i   (s1_byte_r),
    .part_i   (part_r),
    .rem_i    (rem_r),
    .res_o    (res),
    .part_nxt (part_nxt),
    .rem_nxt  (rem_nxt)
  );

  u8u16_obuf u_obuf (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (s1_adv),
    .res      (res),
    .can_take (can_take),
    .status   (ob_status),
    .out_ch   (out_ch)
  );

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    ob_status.count != 2'd3)
    else $error("result buffer overfilled");

  a_idle_part: assert property (@(posedge clk) disable iff (!rst_n)
    (rem_r == u8u16_pkg::REM_NONE) |-> (part_r == '0))
    else $error("partial value left with no sequence pending");

  a_pair_out: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_adv && (res.n == 2'd2)) |=> (out_ch.valid && (ob_status.count == 2'd2)))
    else $error("two-unit beat not held");

  a_eos_unit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.end_of_string) |->
      ((out_ch.code_unit == 16'd0) && out_ch.last_of_run))
    else $error("terminator unit malformed");

endmodule
`default_nettype wire

// File: design/u8u16_step.sv
// Decode step: one byte plus sequence state gives up to two code units and next state.
`default_nettype none
module u8u16_step (
  input  wire logic [u8u16_pkg::BYTE_W-1:0] byte_i,
  input  wire logic [u8u16_pkg::PART_W-1:0] part_i,
  input  wire logic [1:0]                   rem_i,
  output u8u16_pkg::step_res_t              res_o,
  output logic      [u8u16_pkg::PART_W-1:0] part_nxt,
  output logic      [1:0]                   rem_nxt
);

  logic [u8u16_pkg::CP_W-1:0] cp;
  logic [u8u16_pkg::CP_W-1:0] cp_off;
  logic                       is_cont;
  logic                       is_ascii;
  logic                       pending;
  logic [u8u16_pkg::PART_W-1:0] lead_part;
  logic [1:0]                 lead_rem;

  always_comb begin
    cp       = {part_i, byte_i[5:0]};
    cp_off   = cp - u8u16_pkg::SUPP_BASE;
    is_cont  = (byte_i[7:6] == 2'b10);
    is_ascii = ~byte_i[7];
    pending  = (rem_i != u8u16_pkg::REM_NONE);

    lead_part = '0;
    lead_rem  = u8u16_pkg::REM_NONE;
    if (byte_i[7:3] == 5'b11110) begin
      lead_part = {12'd0, byte_i[2:0]};
      lead_rem  = u8u16_pkg::REM_THREE;
    end else if (byte_i[7:4] == 4'b1110) begin
      lead_part = {11'd0, byte_i[3:0]};
      lead_rem  = u8u16_pkg::REM_TWO;
    end else if (byte_i[7:5] == 3'b110) begin
      lead_part = {10'd0, byte_i[4:0]};
      lead_rem  = u8u16_pkg::REM_ONE;
    end
  end

  always_comb begin
    res_o    = '0;
    part_nxt = part_i;
    rem_nxt  = rem_i;
    if (byte_i == '0) begin
      part_nxt = '0;
      rem_nxt  = u8u16_pkg::REM_NONE;
      res_o.u0 = '{code_unit: '0, end_of_string: 1'b1, last_of_run: 1'b1};
      res_o.n  = 2'd1;
    end else if (pending && is_cont) begin
      rem_nxt = rem_i - 2'd1;
      if (rem_i == u8u16_pkg::REM_ONE) begin
        part_nxt = '0;
        if (cp[20:16] == '0) begin
          res_o.u0 = '{code_unit: cp[15:0], end_of_string: 1'b0, last_of_run: 1'b1};
          res_o.n  = 2'd1;
        end else begin
          res_o.u0 = '{code_unit: {u8u16_pkg::SURR_HI, cp_off[19:10]},
                       end_of_string: 1'b0, last_of_run: 1'b0};
          res_o.u1 = '{code_unit: {u8u16_pkg::SURR_LO, cp_off[9:0]},
                       end_of_string: 1'b0, last_of_run: 1'b1};
          res_o.n  = 2'd2;
        end
      end else begin
        part_nxt = cp[14:0];
      end
    end else begin
      // interrupted sequence flushes the partial value first
      part_nxt = is_ascii ? '0 : lead_part;
      rem_nxt  = is_ascii ? u8u16_pkg::REM_NONE : lead_rem;
      if (pending) begin
        res_o.u0 = '{code_unit: {1'b0, part_i}, end_of_string: 1'b0,
                     last_of_run: byte_i[7]};
        if (is_ascii) begin
          res_o.u1 = '{code_unit: {8'd0, byte_i}, end_of_string: 1'b0, last_of_run: 1'b1};
          res_o.n  = 2'd2;
        end else begin
          res_o.n  = 2'd1;
        end
      end else if (is_ascii) begin
        res_o.u0 = '{code_unit: {8'd0, byte_i}, end_of_string: 1'b0, last_of_run: 1'b1};
        res_o.n  = 2'd1;
      end
    end
  end

endmodule
`default_nettype wire

// File: design/u8u16_obuf.sv
// Two-entry result register that delivers code units one beat at a time.
`default_nettype none
module u8u16_obuf (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 push,
  input  wire u8u16_pkg::step_res_t res,
  output logic                      can_take,
  output u8u16_pkg::obuf_status_t   status,
  u8u16_out_if.source               out_ch
);

  logic [1:0]       cnt_r;
  u8u16_pkg::unit_t ent0_r;
  u8u16_pkg::unit_t ent1_r;
  logic             pop;

  always_comb begin
    pop      = (cnt_r != 2'd0) && out_ch.ready;
    can_take = (cnt_r == 2'd0) || ((cnt_r == 2'd1) && out_ch.ready);
    status.count         = cnt_r;
    out_ch.valid         = (cnt_r != 2'd0);
    out_ch.code_unit     = ent0_r.code_unit;
    out_ch.end_of_string = ent0_r.end_of_string;
    out_ch.last_of_run   = ent0_r.last_of_run;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else if (push) begin
      cnt_r <= res.n;
    end else if (pop) begin
      cnt_r <= cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      ent0_r <= res.u0;
      ent1_r <= res.u1;
    end else if (pop) begin
      ent0_r <= ent1_r;
    end
  end

endmodule
`default_nettype wire
